>>> hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks that a condition implies a consequence, both sampled on the clock.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

`endif

>>> hdl/dlsf_pkg.sv
// Package with the shared constants and types of the dense layer sigmoid unit.
`timescale 1ns / 1ps

package dlsf_pkg;

    // Default sizes of the layer.
    localparam int DEF_MAX_INPUTS  = 16;
    localparam int DEF_MAX_OUTPUTS = 16;
    localparam int DEF_DATA_WIDTH  = 16;

    // Port field widths.
    localparam int CMD_W   = 2;
    localparam int ROW_W   = 4;
    localparam int COL_W   = 4;
    localparam int VALUE_W = 16;
    localparam int OIDX_W  = 4;
    localparam int ACT_W   = 16;
    localparam int CFG_W   = 5;

    // Accumulator width, Q16.16 with headroom for the longest vector.
    localparam int ACC_W = 40;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BIAS   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INPUT  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_IN_COUNT  = 1'b0;
    localparam logic CFG_OUT_COUNT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] IN_COUNT_RST  = 5'd3;
    localparam logic [CFG_W-1:0] OUT_COUNT_RST = 5'd2;

    // Piecewise-linear sigmoid breakpoints and offsets, Q16.16 in and Q0.16 out.
    localparam int SIG_SAT  = 327680;
    localparam int SIG_K2   = 155648;
    localparam int SIG_K1   = 65536;
    localparam int SIG_OFF2 = 55296;
    localparam int SIG_OFF1 = 40960;
    localparam int SIG_OFF0 = 32768;
    localparam int SIG_ONE  = 65536;

    // Magnitude bits kept below the saturation point, and width of the half value.
    localparam int A_W = 19;
    localparam int P_W = 17;

    // Control of one beat moving through the shared datapath.
    typedef struct packed {
        logic mac;
        logic act;
        logic last;
    } pipe_ctrl_t;

endpackage

>>> hdl/dlsf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module dlsf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/dlsf_mac.sv
// Shared multiply-accumulate unit: one weight times one element added to one accumulator.
`timescale 1ns / 1ps

module dlsf_mac
    import dlsf_pkg::*;
#(
    parameter int DATA_W = 16,
    parameter int IDX_W  = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pipe_ctrl_t              in_ctrl,
    input  logic [IDX_W-1:0]        in_idx,
    input  logic signed [DATA_W-1:0] weight,
    input  logic signed [DATA_W-1:0] x,
    input  logic signed [ACC_W-1:0] acc_in,
    output logic                    wr_en,
    output logic [IDX_W-1:0]        wr_idx,
    output logic signed [ACC_W-1:0] wr_data
);

    logic                           vld_reg;
    logic [IDX_W-1:0]               idx_reg;
    logic signed [2*DATA_W-1:0]     prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_ctrl.mac;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= in_idx;
        prod_reg <= weight * x;
        acc_reg  <= acc_in;
    end

    assign wr_en   = vld_reg;
    assign wr_idx  = idx_reg;
    assign wr_data = acc_reg + ACC_W'(prod_reg);

endmodule

>>> hdl/dlsf_act.sv
// Activation pipeline: bias add, magnitude, and piecewise-linear sigmoid.
`timescale 1ns / 1ps

module dlsf_act
    import dlsf_pkg::*;
#(
    parameter int DATA_W = 16,
    parameter int IDX_W  = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pipe_ctrl_t               in_ctrl,
    input  logic [IDX_W-1:0]         in_idx,
    input  logic signed [DATA_W-1:0] bias,
    input  logic signed [ACC_W-1:0]  acc_in,
    output logic                     result_valid,
    output logic [OIDX_W-1:0]        out_index,
    output logic [ACT_W-1:0]         activation,
    output logic                     last
);

    localparam int Z_W = ACC_W + 1;

    // Stage A: pre-activation.
    logic                  a_vld_reg;
    logic                  a_last_reg;
    logic [IDX_W-1:0]      a_idx_reg;
    logic signed [Z_W-1:0] z_reg;
    logic signed [Z_W-1:0] z_next;

    // Stage B: sign, saturation flag and magnitude.
    logic                  b_vld_reg;
    logic                  b_last_reg;
    logic [IDX_W-1:0]      b_idx_reg;
    logic                  b_neg_reg;
    logic                  b_big_reg;
    logic [A_W-1:0]        b_mag_reg;
    logic [Z_W-1:0]        mag_full;

    // Stage C: output register.
    logic                  c_vld_reg;
    logic                  c_last_reg;
    logic [OIDX_W-1:0]     c_idx_reg;
    logic [ACT_W-1:0]      c_act_reg;
    logic [P_W-1:0]        half_p;
    logic [P_W-1:0]        sig_r;
    logic [ACT_W-1:0]      act_next;

    assign z_next   = Z_W'(acc_in) + (Z_W'(bias) <<< 8);
    assign mag_full = z_reg[Z_W-1] ? Z_W'(-z_reg) : Z_W'(z_reg);

    always_comb
    begin
        if (b_big_reg)
        begin
            half_p = P_W'(SIG_ONE);
        end
        else if (b_mag_reg >= A_W'(SIG_K2))
        begin
            half_p = P_W'(b_mag_reg >> 5) + P_W'(SIG_OFF2);
        end
        else if (b_mag_reg >= A_W'(SIG_K1))
        begin
            half_p = P_W'(b_mag_reg >> 3) + P_W'(SIG_OFF1);
        end
        else
        begin
            half_p = P_W'(b_mag_reg >> 2) + P_W'(SIG_OFF0);
        end
        sig_r = b_neg_reg ? (P_W'(SIG_ONE) - half_p) : half_p;
        // Only a full positive half reaches the top bit; it saturates to all ones.
        act_next = sig_r[P_W-1] ? {ACT_W{1'b1}} : sig_r[ACT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= in_ctrl.act;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_last_reg <= in_ctrl.last;
        a_idx_reg  <= in_idx;
        z_reg      <= z_next;

        b_last_reg <= a_last_reg;
        b_idx_reg  <= a_idx_reg;
        b_neg_reg  <= z_reg[Z_W-1];
        b_big_reg  <= (mag_full >= Z_W'(SIG_SAT));
        b_mag_reg  <= mag_full[A_W-1:0];

        c_last_reg <= b_last_reg;
        c_idx_reg  <= OIDX_W'(b_idx_reg);
        c_act_reg  <= act_next;
    end

    assign result_valid = c_vld_reg;
    assign out_index    = c_idx_reg;
    assign activation   = c_act_reg;
    assign last         = c_vld_reg & c_last_reg;

endmodule

>>> hdl/dense_layer_sigmoid_forward_unit.sv
// Dense layer forward pass with sigmoid, on one shared multiplier under a small sequencer.
// Weight and bias writes leave busy low; an input element keeps busy high while the single
// multiplier visits every accumulator once. The final element then issues n outputs (n is
// out_count held to 1..MAX_OUTPUTS); its results come one per cycle, each strobed once; no
// receiver stall. Reset clears the configuration to its defaults, the accumulators (by valid
// bits) and the counter.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dense_layer_sigmoid_forward_unit
    import dlsf_pkg::*;
#(
    parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
    parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
    parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [CMD_W-1:0]          command,
    input  logic [ROW_W-1:0]          row,
    input  logic [COL_W-1:0]          col,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      cfg_write,
    input  logic                      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    output logic                      result_valid,
    output logic [OIDX_W-1:0]         out_index,
    output logic [ACT_W-1:0]          activation,
    output logic                      last
);

    localparam int EW      = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int IDX_W   = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int ECW     = $clog2(MAX_INPUTS + 1);
    localparam int W_DEPTH = MAX_INPUTS * MAX_OUTPUTS;
    localparam int W_AW    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int CW_A    = (ECW > CFG_W) ? ECW : CFG_W;
    localparam int CW_B    = $clog2(MAX_OUTPUTS + 1);
    localparam int CMP_W   = ((CW_A > CW_B) ? CW_A : CW_B) + 1;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_MAC      = 5'b00010,
        ST_MAC_WAIT = 5'b00100,
        ST_OUT      = 5'b01000,
        ST_OUT_WAIT = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        j_reg, j_next;
    logic [ECW-1:0]          cnt_reg, cnt_next;
    logic                    emit_reg, emit_next;
    logic [CFG_W-1:0]        in_count_reg, out_count_reg;
    logic [MAX_OUTPUTS-1:0]  acc_valid_reg, acc_valid_next;
    logic signed [EW-1:0]    x_reg;
    pipe_ctrl_t              s1_ctrl_reg, iss_ctrl;
    logic [IDX_W-1:0]        s1_idx_reg;

    logic                    accept;
    logic                    elem_accept;
    logic                    row_ok, col_ok;
    logic                    w_wr_en, b_wr_en;
    logic [W_AW-1:0]         w_wr_addr, w_rd_addr;
    logic [EW-1:0]           w_rdata, b_rdata;
    logic [ACC_W-1:0]        acc_rdata;
    logic signed [ACC_W-1:0] acc_sel;
    logic [CMP_W-1:0]        n_in, n_out;
    logic                    j_out_last;

    logic                    mac_wr_en;
    logic [IDX_W-1:0]        mac_wr_idx;
    logic signed [ACC_W-1:0] mac_wr_data;

    assign busy        = (state_reg != ST_IDLE);
    assign accept      = start && !busy;
    assign elem_accept = accept && (command == CMD_INPUT);
    assign row_ok      = (int'(row) < MAX_INPUTS);
    assign col_ok      = (int'(col) < MAX_OUTPUTS);
    assign w_wr_en     = accept && (command == CMD_WEIGHT) && row_ok && col_ok;
    assign b_wr_en     = accept && (command == CMD_BIAS) && col_ok;
    assign w_wr_addr   = W_AW'(row) * W_AW'(MAX_OUTPUTS) + W_AW'(col);
    assign w_rd_addr   = W_AW'(cnt_reg) * W_AW'(MAX_OUTPUTS) + W_AW'(j_reg);

    // Counts of zero act as one, counts above the store size act as the size.
    always_comb
    begin
        if (in_count_reg == '0)
        begin
            n_in = CMP_W'(1);
        end
        else if (CMP_W'(in_count_reg) > CMP_W'(MAX_INPUTS))
        begin
            n_in = CMP_W'(MAX_INPUTS);
        end
        else
        begin
            n_in = CMP_W'(in_count_reg);
        end

        if (out_count_reg == '0)
        begin
            n_out = CMP_W'(1);
        end
        else if (CMP_W'(out_count_reg) > CMP_W'(MAX_OUTPUTS))
        begin
            n_out = CMP_W'(MAX_OUTPUTS);
        end
        else
        begin
            n_out = CMP_W'(out_count_reg);
        end
    end

    assign j_out_last = (CMP_W'(j_reg) == (n_out - CMP_W'(1)));

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg  <= IN_COUNT_RST;
            out_count_reg <= OUT_COUNT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IN_COUNT:  in_count_reg  <= cfg_data;
                CFG_OUT_COUNT: out_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        emit_next      = emit_reg;
        acc_valid_next = acc_valid_reg;
        iss_ctrl       = '0;

        if (mac_wr_en)
        begin
            acc_valid_next[mac_wr_idx] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (elem_accept)
                begin
                    state_next = ST_MAC;
                    j_next     = '0;
                    emit_next  = ((CMP_W'(cnt_reg) + CMP_W'(1)) >= n_in);
                end
            end
            ST_MAC:
            begin
                iss_ctrl.mac = 1'b1;
                if (j_reg == IDX_W'(MAX_OUTPUTS - 1))
                begin
                    state_next = ST_MAC_WAIT;
                    j_next     = '0;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_MAC_WAIT:
            begin
                // The last accumulator write lands on the edge that leaves this state.
                if (!s1_ctrl_reg.mac)
                begin
                    if (emit_reg)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        cnt_next   = ECW'(cnt_reg + 1'b1);
                    end
                end
            end
            ST_OUT:
            begin
                iss_ctrl.act  = 1'b1;
                iss_ctrl.last = j_out_last;
                if (j_out_last)
                begin
                    state_next = ST_OUT_WAIT;
                    j_next     = '0;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_OUT_WAIT:
            begin
                if (result_valid && last)
                begin
                    state_next     = ST_IDLE;
                    cnt_next       = '0;
                    acc_valid_next = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            j_reg         <= '0;
            cnt_reg       <= '0;
            emit_reg      <= 1'b0;
            acc_valid_reg <= '0;
            s1_ctrl_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            cnt_reg       <= cnt_next;
            emit_reg      <= emit_next;
            acc_valid_reg <= acc_valid_next;
            s1_ctrl_reg   <= iss_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= j_reg;
        if (elem_accept)
        begin
            x_reg <= value[EW-1:0];
        end
    end

    // An accumulator that has not been written since the vector began reads as zero.
    assign acc_sel = acc_valid_reg[s1_idx_reg] ? $signed(acc_rdata) : '0;

    dlsf_ram #(
        .WIDTH (EW),
        .DEPTH (W_DEPTH)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (w_wr_en),
        .wr_addr (w_wr_addr),
        .wr_data (value[EW-1:0]),
        .rd_addr (w_rd_addr),
        .rd_data (w_rdata)
    );

    dlsf_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_OUTPUTS)
    ) u_bias_ram (
        .clk     (clk),
        .wr_en   (b_wr_en),
        .wr_addr (IDX_W'(col)),
        .wr_data (value[EW-1:0]),
        .rd_addr (j_reg),
        .rd_data (b_rdata)
    );

    dlsf_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_OUTPUTS)
    ) u_acc_ram (
        .clk     (clk),
        .wr_en   (mac_wr_en),
        .wr_addr (mac_wr_idx),
        .wr_data (mac_wr_data),
        .rd_addr (j_reg),
        .rd_data (acc_rdata)
    );

    dlsf_mac #(
        .DATA_W (EW),
        .IDX_W  (IDX_W)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctrl (s1_ctrl_reg),
        .in_idx  (s1_idx_reg),
        .weight  (w_rdata),
        .x       (x_reg),
        .acc_in  (acc_sel),
        .wr_en   (mac_wr_en),
        .wr_idx  (mac_wr_idx),
        .wr_data (mac_wr_data)
    );

    dlsf_act #(
        .DATA_W (EW),
        .IDX_W  (IDX_W)
    ) u_act (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ctrl      (s1_ctrl_reg),
        .in_idx       (s1_idx_reg),
        .bias         (b_rdata),
        .acc_in       (acc_sel),
        .result_valid (result_valid),
        .out_index    (out_index),
        .activation   (activation),
        .last         (last)
    );

    // Results appear only while the output phase runs.
    `ASSERT_IMPL(a_result_in_out, result_valid, ((state_reg == ST_OUT) || (state_reg == ST_OUT_WAIT)), "result beat outside the output phase")
    // Accumulator writes happen only while an element is being accumulated.
    `ASSERT_IMPL(a_acc_wr_in_mac, mac_wr_en, ((state_reg == ST_MAC) || (state_reg == ST_MAC_WAIT)), "accumulator write outside the accumulate phase")
    // The final beat of a vector returns the block to idle.
    `ASSERT_IMPL(a_last_ends, (result_valid && last), ##1 !busy, "block still busy after the final beat")
    // The accumulate and output paths never carry a beat at the same time.
    `ASSERT_CLK(a_ctrl_excl, !(s1_ctrl_reg.mac && s1_ctrl_reg.act), "both datapaths issued in one cycle")

endmodule

>>> test/tb_dense_layer_sigmoid_forward_unit.sv
// Self-checking testbench for the dense layer sigmoid forward unit.
`timescale 1ns / 1ps

module tb_dense_layer_sigmoid_forward_unit
    import dlsf_pkg::*;
();

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 24;
    localparam int END_WAIT      = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 64;
    localparam int CALM_ITEMS    = 16;
    localparam int MAX_IN        = DEF_MAX_INPUTS;
    localparam int MAX_OUT       = DEF_MAX_OUTPUTS;

    // The fourth command code is not decoded by the block.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [OIDX_W-1:0] idx;
        logic [ACT_W-1:0]  act;
        logic              last;
    } act_beat_t;

    typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

    typedef struct packed {
        step_kind_t         kind;
        logic [CMD_W-1:0]   cmd;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [VALUE_W-1:0] value;
        logic               typed;
        logic [ACT_W-1:0]   typed_act;
        logic               reg_idx;
        logic [CFG_W-1:0]   reg_val;
    } dir_step_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [CMD_W-1:0]          command;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
    logic                      cfg_write;
    logic                      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      result_valid;
    logic [OIDX_W-1:0]         out_index;
    logic [ACT_W-1:0]          activation;
    logic                      last;

    // Shadow copy of the layer: stores, sums, element count and the two counts.
    logic signed [VALUE_W-1:0] weight_mem [MAX_IN][MAX_OUT];
    logic signed [VALUE_W-1:0] bias_mem [MAX_OUT];
    logic signed [ACC_W-1:0]   neuron_sum [MAX_OUT];
    int                        elem_count;
    logic [CFG_W-1:0]          in_count_sh;
    logic [CFG_W-1:0]          out_count_sh;

    act_beat_t   expected_acts [$];
    act_beat_t   want;
    dir_step_t   dir_steps [$];
    int          mismatches  = 0;
    int          cycle_count = 0;

    dense_layer_sigmoid_forward_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .row          (row),
        .col          (col),
        .value        (value),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .out_index    (out_index),
        .activation   (activation),
        .last         (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_acts.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat index %0d act %0d",
                                          out_index, activation));
            end
            else
            begin
                want = expected_acts.pop_front();
                if (out_index !== want.idx)
                    report_mismatch($sformatf("out_index %0d, want %0d", out_index, want.idx));
                if (activation !== want.act)
                    report_mismatch($sformatf("activation %0d, want %0d (index %0d)",
                                              activation, want.act, want.idx));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b (index %0d)",
                                              last, want.last, want.idx));
            end
        end
    end

    // Piecewise-linear sigmoid of a Q16.16 pre-activation, returned as Q0.16.
    function automatic logic [ACT_W-1:0] plan_act(input logic signed [ACC_W-1:0] z);
        logic [ACC_W-1:0] mag;
        logic [P_W-1:0]   half;
        mag = z[ACC_W-1] ? -z : z;
        if (mag >= ACC_W'(SIG_SAT))
            half = P_W'(SIG_ONE);
        else if (mag >= ACC_W'(SIG_K2))
            half = P_W'(mag >> 5) + P_W'(SIG_OFF2);
        else if (mag >= ACC_W'(SIG_K1))
            half = P_W'(mag >> 3) + P_W'(SIG_OFF1);
        else
            half = P_W'(mag >> 2) + P_W'(SIG_OFF0);
        if (z[ACC_W-1])
            half = P_W'(SIG_ONE) - half;
        if (half > 17'd65535)
            half = 17'd65535;
        return half[ACT_W-1:0];
    endfunction

    // Advances the shadow layer by one accepted beat and queues the activations it causes.
    task automatic apply_beat(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] r,
                              input logic [COL_W-1:0] c, input logic signed [VALUE_W-1:0] v,
                              input logic typed, input logic [ACT_W-1:0] typed_act);
        int                      n_in;
        int                      n_out;
        logic signed [ACC_W-1:0] bias_ext;
        logic signed [ACC_W-1:0] z;
        act_beat_t               beat;
        case (cmd)
            CMD_WEIGHT: weight_mem[r][c] = v;
            CMD_BIAS:   bias_mem[c] = v;
            CMD_INPUT:
            begin
                if (elem_count < MAX_IN)
                    for (int j = 0; j < MAX_OUT; j++)
                        neuron_sum[j] = neuron_sum[j] +
                                        ACC_W'(weight_mem[elem_count][j]) * ACC_W'(v);
                elem_count++;
                n_in = (in_count_sh == 0) ? 1 : (in_count_sh > MAX_IN) ? MAX_IN : in_count_sh;
                if (elem_count >= n_in)
                begin
                    n_out = (out_count_sh == 0) ? 1 :
                            (out_count_sh > MAX_OUT) ? MAX_OUT : out_count_sh;
                    for (int j = 0; j < n_out; j++)
                    begin
                        bias_ext  = ACC_W'(bias_mem[j]);
                        z         = neuron_sum[j] + (bias_ext <<< 8);
                        beat.idx  = OIDX_W'(j);
                        beat.act  = typed ? typed_act : plan_act(z);
                        beat.last = (j == n_out - 1);
                        expected_acts.push_back(beat);
                    end
                    for (int j = 0; j < MAX_OUT; j++)
                        neuron_sum[j] = '0;
                    elem_count = 0;
                end
            end
            default: ;
        endcase
    endtask

    // Holds the beat on the port until the block takes it.
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] r,
                             input logic [COL_W-1:0] c, input logic [VALUE_W-1:0] v,
                             input logic typed, input logic [ACT_W-1:0] typed_act);
        start   <= 1'b1;
        command <= cmd;
        row     <= r;
        col     <= c;
        value   <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_beat(cmd, r, c, v, typed, typed_act);
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 19))
            @(posedge clk);
    endtask

    // Waits for every queued activation and for the block to settle.
    task automatic drain();
        start <= 1'b0;
        while (expected_acts.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_IN_COUNT)
            in_count_sh = data;
        else
            out_count_sh = data;
    endtask

    function automatic logic [VALUE_W-1:0] rand_q88();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2, 3:    v = VALUE_W'($urandom);
            default: v = VALUE_W'($urandom_range(0, 1023)) - 16'd512;
        endcase
        return v;
    endfunction

    // Count values: mostly small, with zero, the maximum and above it now and then.
    function automatic logic [CFG_W-1:0] rand_count();
        case ($urandom_range(0, 9))
            0:       return 5'd0;
            1:       return 5'd16;
            2:       return 5'd31;
            3:       return CFG_W'($urandom_range(0, 31));
            default: return CFG_W'($urandom_range(1, 4));
        endcase
    endfunction

    task automatic add_item(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] r,
                            input logic [COL_W-1:0] c, input logic [VALUE_W-1:0] v,
                            input logic typed, input logic [ACT_W-1:0] typed_act);
        dir_step_t s;
        s           = '0;
        s.kind      = STEP_ITEM;
        s.cmd       = cmd;
        s.row       = r;
        s.col       = c;
        s.value     = v;
        s.typed     = typed;
        s.typed_act = typed_act;
        dir_steps.push_back(s);
    endtask

    task automatic add_cfg(input logic idx, input logic [CFG_W-1:0] data);
        dir_step_t s;
        s         = '0;
        s.kind    = STEP_CFG;
        s.reg_idx = idx;
        s.reg_val = data;
        dir_steps.push_back(s);
    endtask

    initial
    begin
        int                 sent;
        int                 n_beats;
        int                 pick;
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] v;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        command   <= CMD_WEIGHT;
        row       <= '0;
        col       <= '0;
        value     <= '0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_IN_COUNT;
        cfg_data  <= '0;

        in_count_sh  = IN_COUNT_RST;
        out_count_sh = OUT_COUNT_RST;
        elem_count   = 0;
        for (int j = 0; j < MAX_OUT; j++)
            neuron_sum[j] = '0;

        // Zero weights and biases: z = 0 gives one half, full-scale biases saturate.
        add_item(CMD_INPUT, 4'd0, 4'd0, 16'h7FFF, 1'b0, 16'd0);
        add_item(CMD_INPUT, 4'd0, 4'd0, 16'h8000, 1'b0, 16'd0);
        add_item(CMD_INPUT, 4'd0, 4'd0, 16'h0000, 1'b1, 16'd32768);
        add_item(CMD_BIAS,  4'd0, 4'd0, 16'h7FFF, 1'b0, 16'd0);
        add_item(CMD_BIAS,  4'd0, 4'd1, 16'h7FFF, 1'b0, 16'd0);
        add_item(CMD_INPUT, 4'd0, 4'd0, 16'h0000, 1'b0, 16'd0);
        add_item(CMD_INPUT, 4'd0, 4'd0, 16'h0000, 1'b0, 16'd0);
        add_item(CMD_INPUT, 4'd0, 4'd0, 16'h0000, 1'b1, 16'd65535);
        add_item(CMD_BIAS,  4'd0, 4'd0, 16'h8000, 1'b0, 16'd0);
        add_item(CMD_BIAS,  4'd0, 4'd1, 16'h8000, 1'b0, 16'd0);
        add_item(CMD_INPUT, 4'd0, 4'd0, 16'h0000, 1'b0, 16'd0);
        add_item(CMD_INPUT, 4'd0, 4'd0, 16'h0000, 1'b0, 16'd0);
        add_item(CMD_INPUT, 4'd0, 4'd0, 16'h0000, 1'b1, 16'd0);
        add_item(CMD_UNUSED, 4'd15, 4'd15, 16'hFFFF, 1'b0, 16'd0);
        add_item(CMD_WEIGHT, 4'd0,  4'd0,  16'h7FFF, 1'b0, 16'd0);
        add_item(CMD_WEIGHT, 4'd15, 4'd15, 16'h8000, 1'b0, 16'd0);
        add_item(CMD_WEIGHT, 4'd1,  4'd1,  16'h0180, 1'b0, 16'd0);
        add_item(CMD_WEIGHT, 4'd2,  4'd0,  16'hFF00, 1'b0, 16'd0);
        add_item(CMD_BIAS,   4'd0,  4'd0,  16'h0000, 1'b0, 16'd0);
        add_item(CMD_BIAS,   4'd0,  4'd1,  16'h0040, 1'b0, 16'd0);
        // Shorten the vector after its first element; the sum so far is kept.
        add_item(CMD_INPUT,  4'd0,  4'd0,  16'h0100, 1'b0, 16'd0);
        add_cfg(CFG_IN_COUNT, 5'd2);
        add_item(CMD_INPUT,  4'd0,  4'd0,  16'h0080, 1'b0, 16'd0);
        // A count of zero behaves as one.
        add_cfg(CFG_IN_COUNT, 5'd0);
        add_cfg(CFG_OUT_COUNT, 5'd0);
        add_item(CMD_INPUT,  4'd0,  4'd0,  16'hFFFF, 1'b0, 16'd0);

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every store entry is written before any element can read it.
        for (int r = 0; r < MAX_IN; r++)
            for (int c = 0; c < MAX_OUT; c++)
                send_beat(CMD_WEIGHT, ROW_W'(r), COL_W'(c), 16'h0000, 1'b0, 16'd0);
        for (int c = 0; c < MAX_OUT; c++)
            send_beat(CMD_BIAS, 4'd0, COL_W'(c), 16'h0000, 1'b0, 16'd0);

        foreach (dir_steps[i])
        begin
            if (dir_steps[i].kind == STEP_CFG)
                write_reg(dir_steps[i].reg_idx, dir_steps[i].reg_val);
            else
                send_beat(dir_steps[i].cmd, dir_steps[i].row, dir_steps[i].col,
                          dir_steps[i].value, dir_steps[i].typed, dir_steps[i].typed_act);
        end

        // Random phases; a phase may start in the middle of a vector.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            write_reg(CFG_IN_COUNT, rand_count());
            write_reg(CFG_OUT_COUNT, rand_count());
            n_beats = $urandom_range(10, 40);
            for (int k = 0; k < n_beats && sent < RANDOM_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    cmd = CMD_WEIGHT;
                else if (pick < 16)
                    cmd = CMD_BIAS;
                else if (pick < 19)
                    cmd = CMD_UNUSED;
                else
                    cmd = CMD_INPUT;
                v = rand_q88();
                if (sent < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
                    idle_burst();
                send_beat(cmd, ROW_W'($urandom_range(0, 15)), COL_W'($urandom_range(0, 15)),
                          v, 1'b0, 16'd0);
                if (cmd != CMD_UNUSED)
                    sent++;
            end
        end

        start <= 1'b0;
        while (expected_acts.size() != 0)
            @(posedge clk);
        repeat (END_WAIT)
            @(posedge clk);
        if (mismatches == 0 && expected_acts.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
